/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Each macro checks one property on the rising edge of clk_i, held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property every cycle outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (conseq)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

/* rtl/ufs_pkg.sv */
// Shared types, constants and character classes of the URL finder stream unit.
// No dependencies; imported by the controller, the datapath and the top level.
package ufs_pkg;

  localparam int SCHEME_MAX = 16;
  localparam int LetIdxW    = (SCHEME_MAX > 1) ? $clog2(SCHEME_MAX) : 1;
  localparam int CntW       = $clog2(SCHEME_MAX + 1);
  localparam int BurstW     = $clog2(SCHEME_MAX + 4);

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChNull  = 8'h00;

  // Separator progress: nothing matched, and the full "://" matched
  localparam logic [1:0] SepNone = 2'd0;
  localparam logic [1:0] SepDone = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BURST,
    ST_FINAL_END
  } ufs_state_e;

  typedef enum logic [1:0] {
    SEL_IN_CHAR,
    SEL_END,
    SEL_BURST
  } out_sel_e;

  typedef struct packed {
    logic     step;       // accept the input beat and update the scan state
    logic     load;       // load the output register
    out_sel_e sel;        // source of the loaded item
    logic     last;       // last result of the current input
    logic     burst_adv;  // advance the burst index
  } ufs_cmd_t;

  typedef struct packed {
    logic inside_url;   // a confirmed URL is open
    logic url_char;     // current input byte is a URL character
    logic cur_last;     // current input byte ends its string
    logic burst_start;  // current input byte confirms a URL
    logic burst_done;   // burst index is on the final item
    logic pend_last;    // confirming byte ended its string
    logic out_free;     // output register can take an item
  } ufs_stat_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_url_char(input logic [7:0] c);
    is_url_char = is_letter(c) ||
                  (c inside {"~", ";", "?", "/", ":", "@", "=", "&", "$", "-",
                             "_", ".", "+", "!", "*", "'", "(", ")", ","});
  endfunction

endpackage

/* rtl/ufs_ctrl.sv */
// Controller of the URL finder stream unit: input handshake and burst sequencing.
// Depends on ufs_pkg for the state, command and status types.
module ufs_ctrl import ufs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ufs_stat_t stat_i,
  output ufs_cmd_t  cmd_o
);

  ufs_state_e state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (stat_i.inside_url && stat_i.url_char && stat_i.cur_last) begin
            state_d = ST_FINAL_END;
          end else if (stat_i.burst_start) begin
            state_d = ST_BURST;
          end
        end
      end
      ST_BURST: begin
        if (stat_i.out_free && stat_i.burst_done) begin
          state_d = stat_i.pend_last ? ST_FINAL_END : ST_IDLE;
        end
      end
      ST_FINAL_END: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o = '{step: 1'b0, load: 1'b0, sel: SEL_END, last: 1'b0, burst_adv: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.step = 1'b1;
          if (stat_i.inside_url) begin
            cmd_o.load = 1'b1;
            cmd_o.sel  = stat_i.url_char ? SEL_IN_CHAR : SEL_END;
            cmd_o.last = !(stat_i.url_char && stat_i.cur_last);
          end
        end
      end
      ST_BURST: begin
        if (stat_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.sel       = SEL_BURST;
          cmd_o.burst_adv = 1'b1;
          cmd_o.last      = stat_i.burst_done && !stat_i.pend_last;
        end
      end
      ST_FINAL_END: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = SEL_END;
          cmd_o.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/ufs_datapath.sv */
// Datapath of the URL finder stream unit: letter store, scan state,
// burst index and output register. Depends on ufs_pkg.
module ufs_datapath import ufs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  input  ufs_cmd_t   cmd_i,
  input  logic       out_ready_i,
  output ufs_stat_t  stat_o,
  output logic       out_valid_o,
  output logic [7:0] out_char_o,
  output logic [2:0] out_user_o,
  output logic       out_last_o
);

  logic [7:0]        store_q [SCHEME_MAX];
  logic [CntW-1:0]   count_q, count_d;
  logic              dropped_q, dropped_d;
  logic [1:0]        sep_q, sep_d;
  logic              inside_q, inside_d;
  logic [7:0]        pend_char_q;
  logic              pend_last_q;
  logic [CntW-1:0]   len_q;
  logic              cut_q;
  logic [BurstW-1:0] idx_q;
  logic              ov_q;
  logic [7:0]        oc_q;
  logic [2:0]        ou_q;
  logic              ol_q;

  logic              letter, url, colon, slash;
  logic              do_scan, wr_en, shift_en, burst_start;
  logic [CntW-1:0]   cnt_eff;
  logic [BurstW-1:0] len_ext, off;
  logic [7:0]        burst_char;
  logic              out_free;

  assign letter = is_letter(in_char_i);
  assign url    = is_url_char(in_char_i);
  assign colon  = (in_char_i == ChColon);
  assign slash  = (in_char_i == ChSlash);

  assign burst_start = !inside_q && (sep_q == SepDone) && url && (count_q != '0);

  // Next scan state for the current byte
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    sep_d     = sep_q;
    inside_d  = inside_q;
    do_scan   = 1'b0;
    cnt_eff   = count_q;
    wr_en     = 1'b0;
    shift_en  = 1'b0;
    if (inside_q) begin
      if (!url) begin
        inside_d  = 1'b0;
        count_d   = '0;
        dropped_d = 1'b0;
        sep_d     = SepNone;
      end
    end else if (sep_q == SepNone) begin
      do_scan = 1'b1;
    end else if (sep_q != SepDone) begin
      if (slash) begin
        sep_d = sep_q + 2'd1;
      end else begin
        // broken separator: rescan the byte with an empty run
        count_d   = '0;
        dropped_d = 1'b0;
        sep_d     = SepNone;
        cnt_eff   = '0;
        do_scan   = 1'b1;
      end
    end else begin
      if (burst_start) begin
        inside_d = 1'b1;
      end
      count_d   = '0;
      dropped_d = 1'b0;
      sep_d     = SepNone;
    end

    if (do_scan) begin
      if (letter) begin
        wr_en = 1'b1;
        if (cnt_eff >= CntW'(SCHEME_MAX)) begin
          shift_en  = 1'b1;
          count_d   = CntW'(SCHEME_MAX);
          dropped_d = 1'b1;
        end else begin
          count_d = cnt_eff + CntW'(1);
        end
      end else if (colon && (cnt_eff != '0)) begin
        sep_d = 2'd1;
      end else begin
        count_d   = '0;
        dropped_d = 1'b0;
      end
    end

    if (in_last_i) begin
      inside_d  = 1'b0;
      count_d   = '0;
      dropped_d = 1'b0;
      sep_d     = SepNone;
    end
  end

  // Update scan control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      sep_q       <= SepNone;
      inside_q    <= 1'b0;
      pend_last_q <= 1'b0;
      idx_q       <= '0;
    end else if (cmd_i.step) begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      sep_q       <= sep_d;
      inside_q    <= inside_d;
      pend_last_q <= in_last_i;
      idx_q       <= '0;
    end else if (cmd_i.burst_adv) begin
      idx_q <= idx_q + BurstW'(1);
    end
  end

  // Write the letter store and snapshot the run for a burst
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pend_char_q <= in_char_i;
      len_q       <= count_q;
      cut_q       <= dropped_q;
      if (wr_en) begin
        if (shift_en) begin
          for (int i = 0; i < SCHEME_MAX - 1; i++) begin
            store_q[i] <= store_q[i+1];
          end
          store_q[SCHEME_MAX-1] <= in_char_i;
        end else begin
          store_q[cnt_eff[LetIdxW-1:0]] <= in_char_i;
        end
      end
    end
  end

  // Pick the burst item: letters, then "://", then the confirming byte
  assign len_ext = BurstW'(len_q);
  assign off     = idx_q - len_ext;

  always_comb begin
    if (idx_q < len_ext) begin
      burst_char = store_q[idx_q[LetIdxW-1:0]];
    end else begin
      case (off)
        BurstW'(0): burst_char = ChColon;
        BurstW'(1): burst_char = ChSlash;
        BurstW'(2): burst_char = ChSlash;
        default:    burst_char = pend_char_q;
      endcase
    end
  end

  assign out_free = !ov_q || out_ready_i;

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Output register payload; user bits are {scheme_cut, url_first, item_kind}
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ol_q <= cmd_i.last;
      case (cmd_i.sel)
        SEL_IN_CHAR: begin
          oc_q <= in_char_i;
          ou_q <= 3'b000;
        end
        SEL_BURST: begin
          oc_q <= burst_char;
          ou_q <= {(idx_q == '0) && cut_q, idx_q == '0, 1'b0};
        end
        default: begin
          oc_q <= ChNull;
          ou_q <= 3'b001;
        end
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign out_user_o  = ou_q;
  assign out_last_o  = ol_q;

  assign stat_o = '{
    inside_url:  inside_q,
    url_char:    url,
    cur_last:    in_last_i,
    burst_start: burst_start,
    burst_done:  idx_q == (len_ext + BurstW'(3)),
    pend_last:   pend_last_q,
    out_free:    out_free
  };

endmodule

/* rtl/url_finder_stream_unit.sv */
// URL finder stream unit: one text byte per beat in, URL bytes and end markers out.
// Results leave through the output register; a confirmed URL's burst follows its confirming byte.
// Throughput: one beat per cycle while the output is free; a confirming byte stalls input
// until its burst and any end marker are sent, as does a URL byte that ends its string.
// Reset clears scan state, FSM and output valid; the letter store is not reset.
// Depends on ufs_pkg, ufs_ctrl and ufs_datapath.
module url_finder_stream_unit import ufs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_char
  input  logic       s_axis_tlast,   // string_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic [2:0] m_axis_tuser,   // [0] item_kind, [1] url_first, [2] scheme_cut
  output logic       m_axis_tlast    // last_of_run
);

  ufs_cmd_t  cmd;
  ufs_stat_t stat;

  // Sequence beats and bursts
  ufs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Scan state, letter store and output register
  ufs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_char_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .out_ready_i (m_axis_tready),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* rtl/ufs_checker.sv */
// Port-level checks of the URL finder stream unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ufs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled output beat stays valid
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped while stalled")

  // End markers carry a zero byte
  `ASSERT_IMPL(a_end_null, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 8'h00, "end marker with nonzero byte")

  // End markers never carry the first-byte or the scheme-cut flag
  `ASSERT_IMPL(a_end_flags, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1] && !m_axis_tuser[2], "end marker with first-byte flags")

  // A cut scheme is flagged only on the first byte of a URL
  `ASSERT_IMPL(a_cut_first, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1], "scheme cut flag off the first byte")

  // An end marker is always the final beat of its input
  `ASSERT_IMPL(a_end_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "end marker not marked last")

endmodule

bind url_finder_stream_unit ufs_checker u_ufs_checker (.*);
